[hdl/aimd_pkg.sv]
package aimd_pkg;

  // fixed field widths of the two channels and the config port
  localparam int SEQ_W      = 32;
  localparam int TIME_W     = 32;
  localparam int WHOLE_W    = 24;
  localparam int TIMEOUT_W  = 16;
  localparam int DUPLIM_W   = 8;
  localparam int DUPCNT_W   = 8;
  localparam int THR_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_LIMIT = 1'b1;

  // reset values and saturation limits
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd100;
  localparam logic [DUPLIM_W-1:0]  DUPLIM_RST   = 8'd3;
  localparam logic [THR_W-1:0]     THR_RST      = 32'd1000000;
  localparam int                   WIN_RST_INT  = 25;
  localparam logic [DUPCNT_W-1:0]  DUPCNT_MAX   = 8'd255;
  localparam logic [WHOLE_W-1:0]   WHOLE_MAX    = 24'hFFFFFF;

endpackage

[hdl/aimd_if.sv]
// ack channel: one acknowledgement per beat
interface aimd_ack_if
  import aimd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  acked_seq;
  logic [TIME_W-1:0] sent_time_ms;
  logic [TIME_W-1:0] arrival_time_ms;

  modport source (output valid, acked_seq, sent_time_ms, arrival_time_ms, input ready);
  modport sink   (input valid, acked_seq, sent_time_ms, arrival_time_ms, output ready);
endinterface

// window channel: one updated window per beat
interface aimd_win_if
  import aimd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WHOLE_W-1:0] window_datagrams;
  logic               in_slow_start;
  logic               loss_detected;

  modport source (output valid, window_datagrams, in_slow_start, loss_detected, input ready);
  modport sink   (input valid, window_datagrams, in_slow_start, loss_detected, output ready);
endinterface

[hdl/aimd_alu.sv]
// Shared add/subtract unit; operands carry headroom so the MSB of a
// difference is the borrow.
module aimd_alu #(
  parameter int W = 34
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o
);

  assign sum_o = a_i + (sub_i ? ~b_i : b_i) + W'(sub_i);

endmodule

[hdl/aimd_congestion_window_update.sv]
// Channel   | Dir | Beat contents
// ack_i     | in  | acked_seq, sent_time_ms, arrival_time_ms
// win_o     | out | window_datagrams, in_slow_start, loss_detected
// cfg_*     | in  | write enable, register index, write data (no handshake)
//
// One ack at a time through a sequencer around a single shared adder.
// Loss path: RTT, LOSS, TRIPLE, FIN; slow start: RTT, LOSS, SSADD, SSCMP,
// then SCALE on exit, FIN; duplicate decrease: RTT, LOSS, SCALE, FIN;
// additive increase: RTT, LOSS, DIV (the bit-serial 2/window divide), INCADD, FIN.
// Reset (rst_ni low, async) restores window 25.0, threshold 1000000,
// slow start, timeout 100 and duplicate limit 3.
// A stalled result sits in the output register while the next ack is taken.
module aimd_congestion_window_update
  import aimd_pkg::*;
#(
  parameter int WINDOW_INT_BITS  = 24,
  parameter int WINDOW_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aimd_ack_if.sink              ack_i,
  aimd_win_if.source            win_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IB   = WINDOW_INT_BITS;
  localparam int FB   = WINDOW_FRAC_BITS;
  localparam int WB   = IB + FB;
  localparam int NQ   = 2 * FB + 2;
  localparam int M1   = (WB > NQ) ? WB : NQ;
  localparam int M2   = (M1 > THR_W + FB) ? M1 : THR_W + FB;
  localparam int AW   = M2 + 2;
  localparam int CNTW = $clog2(NQ);
  localparam int CW   = IB + WHOLE_W;

  localparam logic [WB-1:0]   WIN_MAX  = {WB{1'b1}};
  localparam logic [WB-1:0]   WIN_ONE  = WB'(1) << FB;
  localparam logic [WB-1:0]   WIN_RST  = WB'(WIN_RST_INT) << FB;
  localparam logic [AW-1:0]   WIN_TWO  = AW'(2) << FB;
  localparam logic [CNTW-1:0] CNT_TOP  = CNTW'(NQ - 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RTT    = 10'b0000000010,
    S_LOSS   = 10'b0000000100,
    S_TRIPLE = 10'b0000001000,
    S_SSADD  = 10'b0000010000,
    S_SSCMP  = 10'b0000100000,
    S_SCALE  = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_INCADD = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_e;

  state_e               state_q, state_d;
  logic [TIME_W-1:0]    sent_q, arr_q;
  logic [TIME_W-1:0]    rtt_q, rtt_d;
  logic                 loss_q, loss_d;
  logic [WB-1:0]        win_q, win_d;
  logic [THR_W-1:0]     thr_q, thr_d;
  logic                 ss_q, ss_d;
  logic [SEQ_W-1:0]     prev_seq_q;
  logic [DUPCNT_W-1:0]  dup_q, dup_d;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [DUPLIM_W-1:0]  dup_lim_q;
  logic [WB-1:0]        rem_q, rem_d;
  logic [NQ-1:0]        quo_q, quo_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic                 out_vld_q, out_vld_d;
  logic [WHOLE_W-1:0]   out_whole_q;
  logic                 out_ss_q, out_loss_q;

  logic                 ack_acc, out_load;
  logic [AW-1:0]        alu_a, alu_b, alu_sum;
  logic                 alu_sub, alu_neg;
  logic [WB-1:0]        divisor, sat_win, scaled;
  logic [WB:0]          shifted;
  logic [IB-1:0]        whole;
  logic [CW-1:0]        whole_c;
  logic [WHOLE_W-1:0]   whole_o;

  assign ack_acc     = ack_i.valid && ack_i.ready;
  assign ack_i.ready = (state_q == S_IDLE);

  // shared adder
  aimd_alu #(.W(AW)) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign alu_neg = alu_sum[AW-1];
  assign sat_win = (|alu_sum[AW-1:WB]) ? WIN_MAX : alu_sum[WB-1:0];
  assign scaled  = WB'(alu_sum >> 2);
  assign divisor = (win_q == '0) ? WB'(1) : win_q;
  assign shifted = {rem_q, (cnt_q == CNT_TOP)};

  // operand select per step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_RTT: begin
        alu_a   = AW'(arr_q);
        alu_b   = AW'(sent_q);
        alu_sub = 1'b1;
      end
      S_LOSS: begin
        alu_a   = AW'(timeout_q);
        alu_b   = AW'(rtt_q);
        alu_sub = 1'b1;
      end
      S_TRIPLE, S_SCALE: begin
        alu_a = AW'(win_q);
        alu_b = AW'(win_q) << 1;
      end
      S_SSADD: begin
        alu_a = AW'(win_q);
        alu_b = WIN_TWO;
      end
      S_SSCMP: begin
        alu_a   = AW'(win_q);
        alu_b   = AW'(thr_q) << FB;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = AW'(shifted);
        alu_b   = AW'(divisor);
        alu_sub = 1'b1;
      end
      S_INCADD: begin
        alu_a = AW'(win_q);
        alu_b = AW'(quo_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    rtt_d    = rtt_q;
    loss_d   = loss_q;
    win_d    = win_q;
    thr_d    = thr_q;
    ss_d     = ss_q;
    dup_d    = dup_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (ack_acc) begin
          state_d = S_RTT;
          if (ack_i.acked_seq == prev_seq_q) begin
            if (dup_q != DUPCNT_MAX) dup_d = dup_q + 1'b1;
          end else begin
            dup_d = '0;
          end
        end
      end
      S_RTT: begin
        rtt_d   = alu_sum[TIME_W-1:0];
        state_d = S_LOSS;
      end
      S_LOSS: begin
        loss_d = alu_neg;
        rem_d  = '0;
        cnt_d  = CNT_TOP;
        if (alu_neg) begin
          state_d = S_TRIPLE;
        end else if (ss_q) begin
          state_d = S_SSADD;
        end else if (dup_q >= dup_lim_q) begin
          state_d = S_SCALE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_TRIPLE: begin
        thr_d   = THR_W'(alu_sum >> (FB + 2));
        win_d   = win_q >> 1;
        ss_d    = 1'b1;
        state_d = S_FIN;
      end
      S_SSADD: begin
        win_d   = sat_win;
        state_d = S_SSCMP;
      end
      S_SSCMP: begin
        state_d = alu_neg ? S_FIN : S_SCALE;
      end
      S_SCALE: begin
        // slow-start exit floors at one; duplicate decrease restarts the count
        if (ss_q) begin
          ss_d  = 1'b0;
          win_d = (scaled < WIN_ONE) ? WIN_ONE : scaled;
        end else begin
          dup_d = '0;
          win_d = scaled;
        end
        state_d = S_FIN;
      end
      S_DIV: begin
        // restoring divide of 2^(2F+1) by the window, one quotient bit a cycle
        if (!alu_neg) begin
          rem_d = alu_sum[WB-1:0];
        end else begin
          rem_d = shifted[WB-1:0];
        end
        quo_d = {quo_q[NQ-2:0], ~alu_neg};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_INCADD;
      end
      S_INCADD: begin
        win_d   = sat_win;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_q || win_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // whole part, clamped between one and the largest output value
  assign whole   = win_q[WB-1:FB];
  assign whole_c = CW'(whole);
  always_comb begin
    if (whole_c == '0) begin
      whole_o = WHOLE_W'(1);
    end else if (whole_c > CW'(WHOLE_MAX)) begin
      whole_o = WHOLE_MAX;
    end else begin
      whole_o = whole_c[WHOLE_W-1:0];
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (win_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      win_q      <= WIN_RST;
      thr_q      <= THR_RST;
      ss_q       <= 1'b1;
      prev_seq_q <= '0;
      dup_q      <= '0;
      timeout_q  <= TIMEOUT_RST;
      dup_lim_q  <= DUPLIM_RST;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      win_q     <= win_d;
      thr_q     <= thr_d;
      ss_q      <= ss_d;
      dup_q     <= dup_d;
      out_vld_q <= out_vld_d;
      if (ack_acc) prev_seq_q <= ack_i.acked_seq;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT:   timeout_q <= cfg_data_i;
          CFG_DUP_LIMIT: dup_lim_q <= cfg_data_i[DUPLIM_W-1:0];
          default:       timeout_q <= timeout_q;
        endcase
      end
    end
  end

  // working and output payload
  always_ff @(posedge clk_i) begin
    rtt_q  <= rtt_d;
    loss_q <= loss_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    if (ack_acc) begin
      sent_q <= ack_i.sent_time_ms;
      arr_q  <= ack_i.arrival_time_ms;
    end
    if (out_load) begin
      out_whole_q <= whole_o;
      out_ss_q    <= ss_q;
      out_loss_q  <= loss_q;
    end
  end

  assign win_o.valid            = out_vld_q;
  assign win_o.window_datagrams = out_whole_q;
  assign win_o.in_slow_start    = out_ss_q;
  assign win_o.loss_detected    = out_loss_q;

endmodule

[hdl/aimd_chk.sv]
module aimd_chk
  import aimd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               ack_valid_i,
  input logic               ack_ready_i,
  input logic               win_valid_i,
  input logic               win_ready_i,
  input logic [WHOLE_W-1:0] window_datagrams_i,
  input logic               in_slow_start_i,
  input logic               loss_detected_i
);

  logic ack_acc;
  assign ack_acc = ack_valid_i && ack_ready_i;

  // reported window never drops below one
  a_win_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid_i |-> (window_datagrams_i != '0))
    else $error("window beat below one");

  // a loss always puts the block back into slow start
  a_loss_ss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_valid_i && loss_detected_i) |-> in_slow_start_i)
    else $error("loss beat without slow start");

  // one ack in flight: no new ack the cycle after one is taken
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_acc |=> !ack_ready_i)
    else $error("ack taken while busy");

  // a fresh result never rises right after the cycle in which an ack is taken
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(win_valid_i) |-> !$past(ack_acc))
    else $error("result too early");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_valid_i && !win_ready_i) |=>
      (win_valid_i && $stable(window_datagrams_i) && $stable(in_slow_start_i)
       && $stable(loss_detected_i)))
    else $error("stalled result changed");

endmodule

bind aimd_congestion_window_update aimd_chk u_aimd_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .ack_valid_i        (ack_i.valid),
  .ack_ready_i        (ack_i.ready),
  .win_valid_i        (win_o.valid),
  .win_ready_i        (win_o.ready),
  .window_datagrams_i (win_o.window_datagrams),
  .in_slow_start_i    (win_o.in_slow_start),
  .loss_detected_i    (win_o.loss_detected)
);

[dv/aimd_congestion_window_update_tb.sv]
`timescale 1ns / 100ps

module aimd_congestion_window_update_tb;
  import aimd_pkg::*;

  localparam int INT_BITS     = 24;
  localparam int FRAC_BITS    = 16;
  localparam int WIN_BITS     = INT_BITS + FRAC_BITS;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [63:0] WIN_MAX = (64'd1 << WIN_BITS) - 64'd1;
  localparam logic [63:0] WIN_ONE = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic               slow_start;
    logic               loss;
  } win_beat_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  aimd_ack_if ack_ch ();
  aimd_win_if win_ch ();

  aimd_congestion_window_update #(
    .WINDOW_INT_BITS  (INT_BITS),
    .WINDOW_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ack_i      (ack_ch),
    .win_o      (win_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state and its copy of the registers
  logic [63:0]          cwnd_raw;
  logic [THR_W-1:0]     ssthresh;
  logic                 in_ss;
  logic [SEQ_W-1:0]     last_seq;
  logic [DUPCNT_W-1:0]  dup_cnt;
  logic [TIMEOUT_W-1:0] rtt_limit;
  logic [DUPLIM_W-1:0]  dup_limit;

  win_beat_t expected_windows[$];
  win_beat_t exp_beat;
  int        mismatches;
  int        cycle_cnt;
  int        hold_left;
  bit        no_idle;
  logic [SEQ_W-1:0] next_seq;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("aimd_congestion_window_update test failed");
      $finish;
    end
  end

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > WIN_MAX) ? WIN_MAX : s;
  endfunction

  function automatic logic [63:0] scale_3q(logic [63:0] w);
    return (w * 3) >> 2;
  endfunction

  function automatic void reset_window_model();
    cwnd_raw   = 64'(WIN_RST_INT) << FRAC_BITS;
    ssthresh   = THR_RST;
    in_ss      = 1'b1;
    last_seq   = '0;
    dup_cnt    = '0;
    rtt_limit  = TIMEOUT_RST;
    dup_limit  = DUPLIM_RST;
  endfunction

  // AIMD update for one ack; returns the window beat it should produce
  function automatic win_beat_t predict_window(logic [SEQ_W-1:0] seq,
                                               logic [TIME_W-1:0] sent,
                                               logic [TIME_W-1:0] arr);
    logic [TIME_W-1:0] rtt;
    logic              lost;
    logic [63:0]       w;
    logic [63:0]       div;
    logic [63:0]       whole;
    win_beat_t         r;
    rtt  = arr - sent;
    lost = rtt > TIME_W'(rtt_limit);
    w    = cwnd_raw;

    // duplicate tracking comes first, on every ack
    if (seq == last_seq) begin
      if (dup_cnt != DUPCNT_MAX) dup_cnt = dup_cnt + 1'b1;
    end else begin
      last_seq = seq;
      dup_cnt  = '0;
    end

    if (lost) begin
      ssthresh = THR_W'(scale_3q(w) >> FRAC_BITS);
      w        = w >> 1;
      in_ss    = 1'b1;
    end else if (in_ss) begin
      w = add_sat(w, 2 * WIN_ONE);
      if (w >= (64'(ssthresh) << FRAC_BITS)) begin
        in_ss = 1'b0;
        w     = scale_3q(w);
        if (w < WIN_ONE) w = WIN_ONE;
      end
    end else if (dup_cnt >= dup_limit) begin
      w       = scale_3q(w);
      dup_cnt = '0;
    end else begin
      div = (w == 64'd0) ? 64'd1 : w;
      w   = add_sat(w, (64'd1 << (2 * FRAC_BITS + 1)) / div);
    end

    cwnd_raw = w & WIN_MAX;
    whole    = cwnd_raw >> FRAC_BITS;
    if (whole < 64'd1) whole = 64'd1;
    if (whole > 64'(WHOLE_MAX)) whole = 64'(WHOLE_MAX);
    r.whole      = whole[WHOLE_W-1:0];
    r.slow_start = in_ss;
    r.loss       = lost;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && win_ch.valid && win_ch.ready) begin
      if (expected_windows.size() == 0) begin
        $error("window beat with nothing expected: window %0d ss %0b loss %0b",
               win_ch.window_datagrams, win_ch.in_slow_start, win_ch.loss_detected);
        mismatches++;
      end else begin
        exp_beat = expected_windows.pop_front();
        if (win_ch.window_datagrams !== exp_beat.whole) begin
          $error("window_datagrams: expected %0d, got %0d",
                 exp_beat.whole, win_ch.window_datagrams);
          mismatches++;
        end
        if (win_ch.in_slow_start !== exp_beat.slow_start) begin
          $error("in_slow_start: expected %0b, got %0b",
                 exp_beat.slow_start, win_ch.in_slow_start);
          mismatches++;
        end
        if (win_ch.loss_detected !== exp_beat.loss) begin
          $error("loss_detected: expected %0b, got %0b",
                 exp_beat.loss, win_ch.loss_detected);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    int low_left;
    int r;
    low_left = 0;
    win_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        win_ch.ready <= 1'b0;
      end else if (no_idle) begin
        win_ch.ready <= 1'b1;
      end else if (low_left > 0) begin
        low_left--;
        win_ch.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          win_ch.ready <= 1'b1;
        end else begin
          win_ch.ready <= 1'b0;
          low_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one ack beat; valid stays up when no gap follows
  task automatic send_ack(input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] sent,
                          input logic [TIME_W-1:0] arr);
    int gap;
    ack_ch.valid           <= 1'b1;
    ack_ch.acked_seq       <= seq;
    ack_ch.sent_time_ms    <= sent;
    ack_ch.arrival_time_ms <= arr;
    do @(posedge clk_i); while (!ack_ch.ready);
    expected_windows.push_back(predict_window(seq, sent, arr));
    gap = pick_gap();
    if (gap > 0) begin
      ack_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic ack_quiet();
    ack_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    ack_quiet();
    while (expected_windows.size() != 0) @(posedge clk_i);
  endtask

  // register write, only once the block has gone idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_TIMEOUT:   rtt_limit = data[TIMEOUT_W-1:0];
      CFG_DUP_LIMIT: dup_limit = data[DUPLIM_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // seq 0 right after reset is a duplicate; rtt wrap, boundary, loss, ss exit
  task automatic test_reset_and_slow_start();
    send_ack(32'd0, 32'd0, 32'd0);
    send_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_ack(32'd1, 32'd1000, 32'd1100);
    send_ack(32'd2, 32'd1000, 32'd1101);
    send_ack(32'd3, 32'd0, 32'hFFFF_FFFF);
    send_ack(32'd4, 32'h8000_0000, 32'h8000_0000);
    send_ack(32'd5, 32'h5555_5555, 32'h5555_5560);
    send_ack(32'd6, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
  endtask

  // three repeats of the same seq in avoidance trigger the decrease
  task automatic test_dup_ack_decrease();
    repeat (4) send_ack(32'd6, 32'd10, 32'd20);
    send_ack(32'd7, 32'd10, 32'd20);
    next_seq = 32'd8;
  endtask

  // zero timeout flags any nonzero rtt; max timeout at its boundary
  task automatic test_timeout_extremes();
    cfg_write(CFG_TIMEOUT, 16'd0);
    send_ack(next_seq, 32'd77, 32'd77);
    send_ack(next_seq + 1, 32'd77, 32'd78);
    cfg_write(CFG_TIMEOUT, 16'hFFFF);
    send_ack(next_seq + 2, 32'd0, 32'd65535);
    send_ack(next_seq + 3, 32'd0, 32'd65536);
    next_seq = next_seq + 4;
    cfg_write(CFG_TIMEOUT, TIMEOUT_RST);
  endtask

  // window driven to zero: losses, then decreases with a zero dup limit,
  // then an increase that divides by the floored window
  task automatic test_window_collapse();
    int i;
    for (i = 0; i < 26; i++) begin
      send_ack(next_seq, 32'd0, 32'd500);
      next_seq++;
    end
    send_ack(next_seq, 32'd0, 32'd0);
    next_seq++;
    cfg_write(CFG_DUP_LIMIT, 16'd0);
    for (i = 0; i < 45; i++) begin
      send_ack(next_seq, 32'd5, 32'd9);
      next_seq++;
    end
    // upper data bits are dropped by the 8-bit register
    cfg_write(CFG_DUP_LIMIT, 16'hFFFF);
    send_ack(next_seq, 32'd5, 32'd9);
    send_ack(next_seq + 1, 32'd5, 32'd9);
    next_seq = next_seq + 2;
    repeat (8) send_ack(next_seq, 32'd0, 32'd1000);
    next_seq++;
  endtask

  // receiver holds off while acks keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    wait_drained();
    hold_left = 300;
    no_idle   = 1'b1;
    for (i = 0; i < 30; i++) begin
      send_ack(next_seq, 32'd0, 32'(i % 3));
      next_seq++;
    end
    no_idle = 1'b0;
  endtask

  // random traffic over several register settings
  task automatic test_random_traffic();
    int ph;
    int n;
    int r;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] sent;
    logic [TIME_W-1:0] rtt;
    logic [TIMEOUT_W-1:0] tmo;
    logic [CFG_DATA_W-1:0] dl;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin tmo = TIMEOUT_RST; dl = 16'd3;   end
        1: begin tmo = 16'd0;       dl = 16'd1;   end
        2: begin tmo = 16'hFFFF;    dl = 16'd255; end
        3: begin tmo = 16'd1;       dl = 16'd0;   end
        default: begin
          tmo = TIMEOUT_W'($urandom_range(0, 65535));
          dl  = CFG_DATA_W'($urandom_range(1, 255));
        end
      endcase
      cfg_write(CFG_TIMEOUT, tmo);
      cfg_write(CFG_DUP_LIMIT, dl);
      for (n = 0; n < 205; n++) begin
        no_idle = (n >= 100 && n < 140);
        // mostly in-order acks with dup bursts, some random and edge seqs
        r = $urandom_range(0, 99);
        if (r < 55) begin
          next_seq = next_seq + ((r < 45) ? 32'd1 : $urandom_range(2, 1000));
          seq = next_seq;
        end else if (r < 82) begin
          seq = next_seq;
        end else if (r < 92) begin
          next_seq = $urandom();
          seq = next_seq;
        end else begin
          next_seq = (r < 96) ? 32'd0 : 32'hFFFF_FFFF;
          seq = next_seq;
        end
        // rtt mostly inside the timeout, sometimes just past it
        r = $urandom_range(0, 99);
        if (r < 85)      rtt = $urandom_range(0, int'(tmo));
        else if (r < 90) rtt = TIME_W'(tmo);
        else if (r < 96) rtt = TIME_W'(tmo) + $urandom_range(1, 50);
        else             rtt = $urandom();
        sent = $urandom();
        send_ack(seq, sent, sent + rtt);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    ack_ch.valid           = 1'b0;
    ack_ch.acked_seq       = '0;
    ack_ch.sent_time_ms    = '0;
    ack_ch.arrival_time_ms = '0;
    mismatches = 0;
    cycle_cnt  = 0;
    hold_left  = 0;
    no_idle    = 1'b0;
    next_seq   = '0;
    reset_window_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_slow_start();
    test_dup_ack_decrease();
    test_timeout_extremes();
    test_window_collapse();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_windows.size() == 0) begin
      $display("aimd_congestion_window_update test passed");
    end else begin
      $display("aimd_congestion_window_update test failed");
    end
    $finish;
  end

endmodule
